FILE: sv/chebyshev_2d_clenshaw_eval_unit_macros.svh
// Assertion macros for the Chebyshev 2D evaluator.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef CHEBYSHEV_2D_CLENSHAW_EVAL_UNIT_MACROS_SVH
`define CHEBYSHEV_2D_CLENSHAW_EVAL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define CHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define CHB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHB_ASSERT(lbl, prop, msg)
`define CHB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/chb2d_pkg.sv
`timescale 1ns / 1ps

package chb2d_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int ACC_W       = 48;
  localparam int HALF_W      = ACC_W / 2;
  localparam int PROD_W      = 64;
  localparam int WIDE_W      = PROD_W + 2;
  localparam int MAX_ORDER_N = 32;
  localparam int MAX_ORDER_M = 32;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 5;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int ORDER_W     = 6;
  localparam int INV_W       = 31;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 40;

  // Largest product magnitude handed back by the multiplier
  localparam logic [PROD_W-1:0] CAP_MAG = PROD_W'(1) << (PROD_W - 2);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FULL  = 2'd0,
    MODE_ROW_Y = 2'd1,
    MODE_COL_X = 2'd2,
    MODE_WRITE = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER_N    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_M    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_Y = 3'd5;

  typedef struct packed {
    logic start;
    acc_t op_a;
    acc_t op_b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    prod_t product;
  } mul_rsp_t;

  // Clamp a wide sum to the internal accumulator range
  function automatic acc_t sat_acc(input wide_t v);
    acc_t r;
    if (v > wide_t'({1'b0, {(ACC_W-1){1'b1}}})) begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (v < -wide_t'({1'b0, {(ACC_W-1){1'b1}}}) - wide_t'(1)) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // Clamp an accumulator value to the output word range
  function automatic data_t sat_data(input acc_t v);
    data_t r;
    if (v > acc_t'({1'b0, {(DATA_W-1){1'b1}}})) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -acc_t'({1'b0, {(DATA_W-1){1'b1}}}) - acc_t'(1)) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/chb2d_mul.sv
`timescale 1ns / 1ps

// Sequential signed fractional multiplier: four 24x24 partial products,
// one per cycle, then scale, cap and sign.
module chb2d_mul
  import chb2d_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int FULL_W = 2 * ACC_W;
  localparam int QUOT_W = FULL_W - FRAC_W;

  logic [ACC_W-1:0]  mag_a;
  logic [ACC_W-1:0]  mag_b;
  logic              neg;
  logic [1:0]        sel;
  logic              issuing;
  logic [ACC_W-1:0]  pp;
  logic [1:0]        pp_sel;
  logic              pp_valid;
  logic              fin;
  logic [FULL_W-1:0] acc;
  logic [FULL_W-1:0] pp_shifted;
  logic [HALF_W-1:0] half_a;
  logic [HALF_W-1:0] half_b;
  logic [QUOT_W-1:0] quot;
  logic [PROD_W-1:0] mag_q;

  assign half_a = sel[0] ? mag_a[ACC_W-1:HALF_W] : mag_a[HALF_W-1:0];
  assign half_b = sel[1] ? mag_b[ACC_W-1:HALF_W] : mag_b[HALF_W-1:0];

  always_comb begin
    case (pp_sel)
      2'b00:   pp_shifted = FULL_W'(pp);
      2'b01:   pp_shifted = FULL_W'(pp) << HALF_W;
      2'b10:   pp_shifted = FULL_W'(pp) << HALF_W;
      2'b11:   pp_shifted = FULL_W'(pp) << ACC_W;
      default: pp_shifted = '0;
    endcase
  end

  assign quot  = acc[FULL_W-1:FRAC_W];
  assign mag_q = (quot > QUOT_W'(CAP_MAG)) ? CAP_MAG : quot[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing     <= 1'b0;
      pp_valid    <= 1'b0;
      fin         <= 1'b0;
      sel         <= '0;
      rsp.done    <= 1'b0;
      rsp.product <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        mag_a    <= req.op_a[ACC_W-1] ? ACC_W'(-req.op_a) : ACC_W'(req.op_a);
        mag_b    <= req.op_b[ACC_W-1] ? ACC_W'(-req.op_b) : ACC_W'(req.op_b);
        neg      <= req.op_a[ACC_W-1] ^ req.op_b[ACC_W-1];
        acc      <= '0;
        sel      <= '0;
        issuing  <= 1'b1;
        pp_valid <= 1'b0;
        fin      <= 1'b0;
      end else begin
        if (issuing) begin
          pp       <= half_a * half_b;
          pp_sel   <= sel;
          pp_valid <= 1'b1;
          sel      <= sel + 2'd1;
          if (sel == 2'b11) begin
            issuing <= 1'b0;
          end
        end else begin
          pp_valid <= 1'b0;
        end
        if (pp_valid) begin
          acc <= acc + pp_shifted;
          if (pp_sel == 2'b11) begin
            fin <= 1'b1;
          end
        end
        if (fin) begin
          fin         <= 1'b0;
          rsp.done    <= 1'b1;
          rsp.product <= neg ? -prod_t'(mag_q) : prod_t'(mag_q);
        end
      end
    end
  end

endmodule

FILE: sv/chebyshev_2d_clenshaw_eval_unit.sv
`timescale 1ns / 1ps
`include "chebyshev_2d_clenshaw_eval_unit_macros.svh"

// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+----------------------------------------
// s_axis    | in  | tvalid / tready        | tuser: mode; tdata: x, y, row, col, coeff
// m_axis    | out | tvalid / tready        | tdata: value, index; tlast: last
// cfg       | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// A coefficient write finishes in the idle state. An evaluation maps y then x,
// then runs Clenshaw passes of len+1 multiplies each. The shared multiplier
// (four 24x24 partial products) sets the pace.
// Reset: synchronous, clears control state and config; coefficients are not
// cleared. Output stalls only hold the next result; work continues until it
// needs the output register.
module chebyshev_2d_clenshaw_eval_unit
  import chb2d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] x_val, [63:32] y_val, [68:64] coeff_row, [73:69] coeff_col,
  // [105:74] coeff_value, [111:106] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] value, [36:32] index, [39:37] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_Y,
    S_MAP_X,
    S_PASS,
    S_STEP,
    S_STEP_WAIT,
    S_TAIL,
    S_EMIT
  } state_t;

  // input field unpacking
  data_t              in_x;
  data_t              in_y;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  data_t              in_coeff;
  mode_t              in_mode;

  assign in_x     = s_axis_tdata[DATA_W-1:0];
  assign in_y     = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign in_row   = s_axis_tdata[2*DATA_W+ROW_W-1:2*DATA_W];
  assign in_col   = s_axis_tdata[2*DATA_W+ROW_W+COL_W-1:2*DATA_W+ROW_W];
  assign in_coeff = s_axis_tdata[3*DATA_W+ROW_W+COL_W-1:2*DATA_W+ROW_W+COL_W];
  assign in_mode  = mode_t'(s_axis_tuser);

  // configuration registers
  logic [ORDER_W-1:0] order_n;
  logic [ORDER_W-1:0] order_m;
  data_t              mid_x;
  logic [INV_W-1:0]   inv_half_x;
  data_t              mid_y;
  logic [INV_W-1:0]   inv_half_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_n    <= ORDER_W'(1);
      order_m    <= ORDER_W'(1);
      mid_x      <= '0;
      inv_half_x <= INV_W'(65536);
      mid_y      <= '0;
      inv_half_y <= INV_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORDER_N:    order_n    <= cfg_data[ORDER_W-1:0];
        REG_ORDER_M:    order_m    <= cfg_data[ORDER_W-1:0];
        REG_MID_X:      mid_x      <= cfg_data;
        REG_INV_HALF_X: inv_half_x <= cfg_data[INV_W-1:0];
        REG_MID_Y:      mid_y      <= cfg_data;
        REG_INV_HALF_Y: inv_half_y <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective orders: zero acts as one, anything above the store size clamps.
  logic [ORDER_W-1:0] n_eff;
  logic [ORDER_W-1:0] m_eff;
  logic [ROW_W-1:0]   n_last;
  logic [COL_W-1:0]   m_last;

  always_comb begin
    n_eff = order_n;
    if (n_eff == '0) begin
      n_eff = ORDER_W'(1);
    end else if (n_eff > ORDER_W'(MAX_ORDER_N)) begin
      n_eff = ORDER_W'(MAX_ORDER_N);
    end
    m_eff = order_m;
    if (m_eff == '0) begin
      m_eff = ORDER_W'(1);
    end else if (m_eff > ORDER_W'(MAX_ORDER_M)) begin
      m_eff = ORDER_W'(MAX_ORDER_M);
    end
  end

  assign n_last = ROW_W'(n_eff - ORDER_W'(1));
  assign m_last = COL_W'(m_eff - ORDER_W'(1));

  // sequencer state
  state_t           state;
  mode_t            mode_r;
  data_t            x_r;
  acc_t             x_unit;
  acc_t             y_unit;
  acc_t             t_cur;
  acc_t             two_t;
  acc_t             b1;
  acc_t             b2;
  logic [ROW_W-1:0] outer;
  logic [ROW_W-1:0] k;
  logic [ROW_W-1:0] len_r;
  logic             final_pass;
  acc_t             res;
  logic [ROW_W-1:0] res_index;
  logic             res_last;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;

  // coefficient store and row-result buffer
  data_t             coeff_mem [MAX_ORDER_N*MAX_ORDER_M];
  acc_t              row_buf   [MAX_ORDER_N];
  data_t             mem_q;
  acc_t              row_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              coeff_we;
  logic              row_we;
  acc_t              coef;
  acc_t              step_nb;
  acc_t              tail_r;
  logic              pass_on_x;
  logic signed [DATA_W:0] diff_x;
  logic signed [DATA_W:0] diff_y;

  assign s_axis_tready = (state == S_IDLE);

  // Column passes walk down a column; row passes walk along a row.
  assign rd_addr  = (mode_r == MODE_COL_X) ? {k, outer} : {outer, k};
  assign coeff_we = s_axis_tvalid && s_axis_tready && (in_mode == MODE_WRITE);
  assign row_we   = (state == S_TAIL) && mul_rsp.done &&
                    (mode_r == MODE_FULL) && !final_pass;
  assign coef     = final_pass ? row_q : acc_t'(mem_q);
  assign step_nb  = sat_acc(wide_t'(coef) - wide_t'(b2) + wide_t'(mul_rsp.product));
  assign tail_r   = sat_acc(wide_t'(b1) - wide_t'(mul_rsp.product));
  assign pass_on_x = final_pass || (mode_r == MODE_COL_X);
  assign diff_y   = (DATA_W+1)'(in_y) - (DATA_W+1)'(mid_y);
  assign diff_x   = (DATA_W+1)'(x_r) - (DATA_W+1)'(mid_x);

  always_ff @(posedge clk) begin
    if (coeff_we) begin
      coeff_mem[{in_row, in_col}] <= in_coeff;
    end
    mem_q <= coeff_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_buf[outer] <= tail_r;
    end
    row_q <= row_buf[k];
  end

  chb2d_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode_r        <= MODE_FULL;
      final_pass    <= 1'b0;
      outer         <= '0;
      k             <= '0;
      len_r         <= '0;
      mul_req       <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // Writes finish here; evaluations start by mapping y.
          if (s_axis_tvalid && (in_mode != MODE_WRITE)) begin
            mode_r        <= in_mode;
            x_r           <= in_x;
            final_pass    <= 1'b0;
            outer         <= '0;
            mul_req.start <= 1'b1;
            mul_req.op_a  <= acc_t'(diff_y);
            mul_req.op_b  <= acc_t'({1'b0, inv_half_y});
            state         <= S_MAP_Y;
          end
        end
        S_MAP_Y: begin
          if (mul_rsp.done) begin
            y_unit        <= sat_acc(wide_t'(mul_rsp.product));
            mul_req.start <= 1'b1;
            mul_req.op_a  <= acc_t'(diff_x);
            mul_req.op_b  <= acc_t'({1'b0, inv_half_x});
            state         <= S_MAP_X;
          end
        end
        S_MAP_X: begin
          if (mul_rsp.done) begin
            x_unit <= sat_acc(wide_t'(mul_rsp.product));
            state  <= S_PASS;
          end
        end
        S_PASS: begin
          // Set up one recurrence from the top coefficient down.
          b1    <= '0;
          b2    <= '0;
          k     <= pass_on_x ? n_last : m_last;
          len_r <= pass_on_x ? n_last : m_last;
          t_cur <= pass_on_x ? x_unit : y_unit;
          two_t <= sat_acc((pass_on_x ? wide_t'(x_unit) : wide_t'(y_unit)) <<< 1);
          state <= S_STEP;
        end
        S_STEP: begin
          mul_req.start <= 1'b1;
          mul_req.op_a  <= two_t;
          mul_req.op_b  <= b1;
          state         <= S_STEP_WAIT;
        end
        S_STEP_WAIT: begin
          if (mul_rsp.done) begin
            b1 <= step_nb;
            b2 <= b1;
            if (k == '0) begin
              // closing term uses the value that becomes b2
              mul_req.start <= 1'b1;
              mul_req.op_a  <= t_cur;
              mul_req.op_b  <= b1;
              state         <= S_TAIL;
            end else begin
              k     <= k - ROW_W'(1);
              state <= S_STEP;
            end
          end
        end
        S_TAIL: begin
          if (mul_rsp.done) begin
            res <= tail_r;
            if (mode_r == MODE_FULL) begin
              if (final_pass) begin
                res_index <= '0;
                res_last  <= 1'b1;
                state     <= S_EMIT;
              end else if (outer == n_last) begin
                final_pass <= 1'b1;
                state      <= S_PASS;
              end else begin
                outer <= outer + ROW_W'(1);
                state <= S_PASS;
              end
            end else begin
              res_index <= outer;
              res_last  <= (mode_r == MODE_COL_X) ? (outer == m_last) : (outer == n_last);
              state     <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // Load the output register once it is free or being drained.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_TDATA_W'({res_index, sat_data(res)});
            m_axis_tlast  <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              outer <= outer + ROW_W'(1);
              state <= S_PASS;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Multiplier results arrive only while the sequencer waits for one.
  `CHB_ASSERT(a_mul_done_in_wait, mul_rsp.done |-> (state == S_MAP_Y || state == S_MAP_X || state == S_STEP_WAIT || state == S_TAIL), "multiplier result outside a wait state")
  // A multiply never starts while a new transaction could be taken.
  `CHB_ASSERT_ALWAYS(a_start_not_ready, mul_req.start |-> !s_axis_tready, "multiply started while ready for input")
  // Recurrence index stays within the pass length.
  `CHB_ASSERT(a_k_in_pass, (state == S_STEP || state == S_STEP_WAIT) |-> (k <= len_r), "recurrence index beyond pass length")
  // Row counter stays within the rows in use for row passes.
  `CHB_ASSERT(a_outer_rows, (state == S_PASS && mode_r != MODE_COL_X && !final_pass) |-> (outer <= n_last), "row counter beyond order_n")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import chb2d_pkg::*;

  // Wide signed type for exact products and sums ahead of clamping
  typedef logic signed [127:0] big_t;

  typedef struct packed {
    mode_t                mode;
    data_t                x_val;
    data_t                y_val;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    data_t                coef;
  } eval_req_t;

  typedef struct packed {
    data_t            value;
    logic [ROW_W-1:0] index;
    logic             last;
  } sum_rec_t;

  localparam big_t ACC_HI     = (big_t'(1) <<< (ACC_W - 1)) - 1;
  localparam big_t ACC_LO     = -(big_t'(1) <<< (ACC_W - 1));
  localparam big_t WORD_HI    = (big_t'(1) <<< (DATA_W - 1)) - 1;
  localparam big_t WORD_LO    = -(big_t'(1) <<< (DATA_W - 1));
  localparam big_t PROD_CAP   = big_t'(1) <<< 62;
  localparam int   PASS_LEN   = (MAX_ORDER_N > MAX_ORDER_M) ? MAX_ORDER_N : MAX_ORDER_M;
  localparam int   IDLE_GUARD = 40;
  localparam int   LONG_STALL = 3000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;

  chebyshev_2d_clenshaw_eval_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies, starting from their reset values
  logic [ORDER_W-1:0] order_n_reg = 6'd1;
  logic [ORDER_W-1:0] order_m_reg = 6'd1;
  data_t              mid_x_reg = '0;
  logic [INV_W-1:0]   inv_x_reg = 31'd65536;
  data_t              mid_y_reg = '0;
  logic [INV_W-1:0]   inv_y_reg = 31'd65536;

  data_t      coef_mem [MAX_ORDER_N][MAX_ORDER_M];
  bit         coef_known [MAX_ORDER_N][MAX_ORDER_M];
  big_t       pass_coef [PASS_LEN];

  eval_req_t  pending_reqs [$];
  sum_rec_t   expected_sums [$];
  eval_req_t  offered_req;

  int         send_gap;
  int         sink_stall;
  int         stall_orders;
  int         stall_seen;
  bit         no_idle;
  int         mismatch_count;
  int         results_checked;
  int         setting_count;
  int         mode_counts [4];
  longint     cycle_count;
  longint     cycle_limit = 50000;

  function automatic big_t clamp_acc(input big_t v);
    return (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
  endfunction

  function automatic data_t clamp_word(input big_t v);
    big_t c;
    c = (v > WORD_HI) ? WORD_HI : ((v < WORD_LO) ? WORD_LO : v);
    return data_t'(c[DATA_W-1:0]);
  endfunction

  // Exact product, shifted down toward zero, magnitude capped
  function automatic big_t mul_q16(input big_t a, input big_t b);
    big_t ma, mb, mag;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mag = (ma * mb) >>> FRAC_W;
    if (mag > PROD_CAP) mag = PROD_CAP;
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  function automatic int used_order(input logic [ORDER_W-1:0] r, input int max_order);
    int lim;
    lim = (max_order < 32) ? max_order : 32;
    if (r == 0) return 1;
    if (int'(r) > lim) return lim;
    return int'(r);
  endfunction

  function automatic big_t map_to_unit(input data_t raw, input data_t mid,
                                       input logic [INV_W-1:0] inv);
    big_t d;
    d = clamp_acc(big_t'(raw) - big_t'(mid));
    return clamp_acc(mul_q16(d, big_t'(inv)));
  endfunction

  // Clenshaw recurrence over pass_coef[0..len-1], from the top index down
  function automatic big_t clenshaw_pass(input int len, input big_t t);
    big_t two_t, b1, b2, nb;
    int   k;
    two_t = clamp_acc(t * 2);
    b1 = 0;
    b2 = 0;
    for (k = len - 1; k >= 0; k--) begin
      nb = clamp_acc(big_t'(pass_coef[k]) - b2 + mul_q16(two_t, b1));
      b2 = b1;
      b1 = nb;
    end
    return clamp_acc(b1 - mul_q16(t, b2));
  endfunction

  // Apply one accepted transaction: store a coefficient or queue its sums
  task automatic predict_request(input eval_req_t r);
    int   n, m, i, j;
    big_t xs, ys;
    big_t row_res [MAX_ORDER_N];
    n = used_order(order_n_reg, MAX_ORDER_N);
    m = used_order(order_m_reg, MAX_ORDER_M);
    mode_counts[r.mode]++;
    case (r.mode)
      MODE_WRITE: begin
        coef_mem[r.row][r.col] = r.coef;
      end
      MODE_FULL: begin
        xs = map_to_unit(r.x_val, mid_x_reg, inv_x_reg);
        ys = map_to_unit(r.y_val, mid_y_reg, inv_y_reg);
        for (i = 0; i < n; i++) begin
          for (j = 0; j < m; j++) pass_coef[j] = big_t'(coef_mem[i][j]);
          row_res[i] = clenshaw_pass(m, ys);
        end
        for (i = 0; i < n; i++) pass_coef[i] = row_res[i];
        expected_sums.push_back('{value: clamp_word(clenshaw_pass(n, xs)),
                                  index: '0, last: 1'b1});
      end
      MODE_ROW_Y: begin
        ys = map_to_unit(r.y_val, mid_y_reg, inv_y_reg);
        for (i = 0; i < n; i++) begin
          for (j = 0; j < m; j++) pass_coef[j] = big_t'(coef_mem[i][j]);
          expected_sums.push_back('{value: clamp_word(clenshaw_pass(m, ys)),
                                    index: ROW_W'(i), last: (i == n - 1)});
        end
      end
      default: begin
        xs = map_to_unit(r.x_val, mid_x_reg, inv_x_reg);
        for (j = 0; j < m; j++) begin
          for (i = 0; i < n; i++) pass_coef[i] = big_t'(coef_mem[i][j]);
          expected_sums.push_back('{value: clamp_word(clenshaw_pass(n, xs)),
                                    index: ROW_W'(j), last: (j == m - 1)});
        end
      end
    endcase
  endtask

  // Mostly short gaps, some long ones, none in a phase without idling
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic data_t rand_coef();
    case ($urandom_range(0, 9))
      0: return data_t'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
      1: return data_t'($urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff);
      2, 3: return data_t'($urandom());
      default: return data_t'($urandom_range(0, 262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic data_t rand_point(input data_t mid);
    case ($urandom_range(0, 9))
      0: return data_t'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
      1, 2: return data_t'($urandom());
      default: return mid + data_t'($urandom_range(0, 131072)) - 32'sd65536;
    endcase
  endfunction

  // Driver: present queued transactions, hold until accepted, then idle a while
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_request(offered_req);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          offered_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_TDATA_W'({offered_req.coef, offered_req.col, offered_req.row,
                                        offered_req.y_val, offered_req.x_val});
          s_axis_tuser  <= offered_req.mode;
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // Monitor: check each result against the oldest outstanding sum, then
  // decide whether to accept next cycle
  always @(posedge clk) begin
    sum_rec_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (expected_sums.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(m_axis_tdata), '0);
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata[DATA_W-1:0] !== want.value)
            report_mismatch("value", 64'(m_axis_tdata[DATA_W-1:0]), 64'(want.value));
          if (m_axis_tdata[DATA_W+ROW_W-1:DATA_W] !== want.index)
            report_mismatch("index", 64'(m_axis_tdata[DATA_W+ROW_W-1:DATA_W]),
                            64'(want.index));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        end
      end
      // Start a long hold-off when the stimulus asks for one
      if (stall_orders != stall_seen) begin
        stall_seen = stall_orders;
        sink_stall = LONG_STALL;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  // Watchdog against a hung block or lost results
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Write one register over the configuration channel; block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORDER_N:    order_n_reg = val[ORDER_W-1:0];
      REG_ORDER_M:    order_m_reg = val[ORDER_W-1:0];
      REG_MID_X:      mid_x_reg   = data_t'(val);
      REG_INV_HALF_X: inv_x_reg   = val[INV_W-1:0];
      REG_MID_Y:      mid_y_reg   = data_t'(val);
      REG_INV_HALF_Y: inv_y_reg   = val[INV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic queue_write(input int row, input int col, input data_t val);
    eval_req_t r;
    r.mode  = MODE_WRITE;
    r.x_val = data_t'($urandom());
    r.y_val = data_t'($urandom());
    r.row   = ROW_W'(row);
    r.col   = COL_W'(col);
    r.coef  = val;
    coef_known[row][col] = 1'b1;
    pending_reqs.push_back(r);
    cycle_limit += 200;
  endtask

  // Queue an evaluation; load any coefficient it would read that was never written
  task automatic queue_eval(input mode_t md, input data_t xv, input data_t yv);
    eval_req_t r;
    int        n, m, i, j, res;
    n = used_order(order_n_reg, MAX_ORDER_N);
    m = used_order(order_m_reg, MAX_ORDER_M);
    for (i = 0; i < n; i++)
      for (j = 0; j < m; j++)
        if (!coef_known[i][j]) queue_write(i, j, rand_coef());
    r.mode  = md;
    r.x_val = xv;
    r.y_val = yv;
    r.row   = ROW_W'($urandom_range(0, 31));
    r.col   = COL_W'($urandom_range(0, 31));
    r.coef  = data_t'($urandom());
    pending_reqs.push_back(r);
    res = (md == MODE_FULL) ? 1 : ((md == MODE_ROW_Y) ? n : m);
    cycle_limit += 4 * (10 * (n + 2) * (m + 2) + 64 * res + 64);
  endtask

  // Wait until every transaction is taken and every sum has come back
  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_sums.size() != 0)
      @(negedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
  endtask

  // Reprogram all registers, then queue a random mix of writes and evaluations
  task automatic run_phase(input logic [31:0] n_word, input logic [31:0] m_word,
                           input logic [31:0] mx, input logic [31:0] ix,
                           input logic [31:0] my, input logic [31:0] iy,
                           input int count, input int write_pct);
    int n, m;
    drain();
    write_reg(REG_ORDER_N, n_word);
    write_reg(REG_ORDER_M, m_word);
    write_reg(REG_MID_X, mx);
    write_reg(REG_INV_HALF_X, ix);
    write_reg(REG_MID_Y, my);
    write_reg(REG_INV_HALF_Y, iy);
    setting_count++;
    no_idle = ($urandom_range(0, 3) == 0);
    n = used_order(order_n_reg, MAX_ORDER_N);
    m = used_order(order_m_reg, MAX_ORDER_M);
    repeat (count) begin
      if ($urandom_range(0, 99) < write_pct) begin
        // Mostly hit coefficients in use so later sums see the change
        if ($urandom_range(0, 3) != 0)
          queue_write($urandom_range(0, n - 1), $urandom_range(0, m - 1), rand_coef());
        else
          queue_write($urandom_range(0, 31), $urandom_range(0, 31), rand_coef());
      end else begin
        queue_eval(mode_t'(MODE_W'($urandom_range(0, 2))),
                   rand_point(mid_x_reg), rand_point(mid_y_reg));
      end
    end
  endtask

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(0, 4))
      0: return 32'd32768;
      1: return 32'd131072;
      2: return $urandom();
      default: return 32'd65536;
    endcase
  endfunction

  function automatic logic [31:0] rand_mid();
    return $urandom_range(0, 1) ? $urandom() : 32'(data_t'($urandom_range(0, 262143)) - 32'sd131072);
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at reset settings: one row, one column, unit domains
    queue_write(0, 0, 32'h7fff_ffff);
    queue_eval(MODE_FULL, 32'sd0, 32'sd0);
    queue_eval(MODE_FULL, 32'h7fff_ffff, 32'h8000_0000);
    queue_eval(MODE_ROW_Y, 32'sd0, 32'h7fff_ffff);
    queue_eval(MODE_COL_X, 32'h8000_0000, 32'sd0);
    queue_write(0, 0, 32'h8000_0000);
    queue_eval(MODE_FULL, 32'h8000_0000, 32'h7fff_ffff);
    queue_eval(MODE_ROW_Y, 32'sd0, 32'sd65536);
    queue_eval(MODE_COL_X, -32'sd65536, 32'sd0);
    // Writes at the far corners of the store give no result
    queue_write(31, 31, 32'h7fff_ffff);
    queue_write(31, 0, 32'h8000_0000);
    queue_write(0, 31, 32'hffff_ffff);
    queue_write(0, 0, 32'h0001_8000);
    queue_eval(MODE_FULL, 32'sd32768, -32'sd32768);
    queue_eval(MODE_ROW_Y, 32'sd0, -32'sd1);
    queue_eval(MODE_COL_X, 32'sd1, 32'sd0);

    // Order zero acts as one, order 63 clamps to 32; zero and largest reciprocals
    run_phase(32'd0, 32'd63, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 20, 20);
    run_phase(32'd63, 32'd0, 32'h7fff_ffff, 32'd0, 32'h8000_0000, 32'hffff_ffff, 20, 20);
    // Full 32 by 32 store, only a few evaluations
    run_phase(32'd32, 32'd32, 32'd0, 32'd65536, 32'd0, 32'd65536, 6, 0);

    // Random settings, small orders; first phase holds the sink off so the
    // block backs up and stalls its input
    for (int p = 0; p < 12; p++) begin
      run_phase((32'($urandom()) & ~32'h3f) | 32'($urandom_range(1, (p % 4 == 3) ? 8 : 5)),
                (32'($urandom()) & ~32'h3f) | 32'($urandom_range(1, (p % 4 == 2) ? 8 : 5)),
                rand_mid(), rand_inv(), rand_mid(), rand_inv(), 32, 25);
      if (p == 0) begin
        @(negedge clk);
        stall_orders++;
        cycle_limit += 4 * LONG_STALL;
      end
    end

    drain();
    $display("covered %0d coefficient writes, %0d full, %0d row and %0d column evaluations",
             mode_counts[MODE_WRITE], mode_counts[MODE_FULL], mode_counts[MODE_ROW_Y],
             mode_counts[MODE_COL_X]);
    $display("checked %0d results over %0d register settings, orders up to 32 by 32",
             results_checked, setting_count + 1);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
